// ----- design/lts_pkg.sv -----
// Shared types and constants for the LIS tail search block.
// Holds the result field widths and the controller/datapath command and status bundles.
// No dependencies.
package lts_pkg;

  // Result field widths, fixed by the output format
  localparam int SLOT_W = 9;
  localparam int RUN_W  = 10;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted input beat
    logic decide;  // classify the element against the first and last tail
    logic search;  // run one lower-bound step
    logic commit;  // write the tail, update length, load the result register
  } lts_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_search;  // element in tail range (ends included), length > 1
    logic found;        // lower-bound search has converged
    logic out_free;     // result register can take a new beat
  } lts_stat_t;

endpackage

// ----- design/lis_length_tail_search_unit.sv -----
// LIS tail search unit: one element per beat, one result beat per element.
// An element goes through load, decide, optional lower-bound search steps and commit; at most
// clog2(MAX_LEN) search steps, each one tail store read; commit waits while the result register is held.
// The next element is accepted while the previous result waits in the output register.
// Synchronous active-low reset clears length and control; the tail store is not cleared.
module lis_length_tail_search_unit
  import lts_pkg::*;
#(
  parameter int MAX_LEN    = 512,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [RUN_W-1:0]             out_run_length,
  output logic                         out_overflow,
  output logic                         out_done_res
);

  lts_cmd_t  cmd;
  lts_stat_t stat;

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lts_dp #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_slot       (out_slot),
    .out_run_length (out_run_length),
    .out_overflow   (out_overflow),
    .out_done_res   (out_done_res)
  );

  // Accepted beat keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an element was still in flight");

  // Controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.decide, cmd.search, cmd.commit}))
    else $error("controller issued overlapping commands");

  // A new result only appears after a commit
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result beat raised without a commit");

  // A dropped extension reports the last slot
  a_ovf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_slot == SLOT_W'(MAX_LEN - 1))
    else $error("overflow result carries the wrong slot");

endmodule

// ----- design/lts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the tail store; no dependencies.
module lts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lts_ctrl.sv -----
// Controller state machine for the LIS tail search block.
// Depends on lts_pkg for the command and status bundles.
module lts_ctrl
  import lts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lts_stat_t stat,
  output lts_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequence one element: accept, classify, search when needed, commit once the result register is free
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = stat.need_search ? ST_SEARCH : ST_COMMIT;
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.found) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/lts_dp.sv -----
// Datapath for the LIS tail search block: tail store, length, search registers, result register.
// Depends on lts_pkg and lts_ram.
module lts_dp
  import lts_pkg::*;
#(
  parameter int MAX_LEN    = 512,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lts_cmd_t                     cmd,
  output lts_stat_t                    stat,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SLOT_W-1:0]            out_slot,
  output logic [RUN_W-1:0]             out_run_length,
  output logic                         out_overflow,
  output logic                         out_done_res
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  // Element and sequence state
  logic signed [VALUE_BITS-1:0] key_r;
  logic                         last_r;
  logic [LEN_W-1:0]             len_r;
  logic                         fresh_r;
  logic signed [VALUE_BITS-1:0] tail0_r;
  logic signed [VALUE_BITS-1:0] tlast_r;

  // Per-element decision
  logic [IDX_W-1:0] slot_r;
  logic             ovf_r;
  logic             ext_r;
  logic             start_r;

  // Search window
  logic [IDX_W-1:0] lo_r;
  logic [IDX_W-1:0] hi_r;
  logic [IDX_W-1:0] mid_r;

  // Result register
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [RUN_W-1:0]  out_run_r;
  logic              out_ovf_r;
  logic              out_done_r;

  // Tail store interface
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_raddr;
  logic [VALUE_BITS-1:0]        mem_rdata;
  logic signed [VALUE_BITS-1:0] rd_val;

  // Combinational helpers
  logic             below;
  logic             above;
  logic             full;
  logic [IDX_W-1:0] hi0;
  logic             lt;
  logic [IDX_W-1:0] lo_n;
  logic [IDX_W-1:0] hi_n;
  logic [IDX_W-1:0] mid_n;
  logic [LEN_W-1:0] new_len;

  // Classify against the first and last tail
  assign below = key_r < tail0_r;
  assign above = key_r > tlast_r;
  assign full  = len_r == LEN_W'(MAX_LEN);
  assign hi0   = IDX_W'(len_r - LEN_W'(1));

  // One lower-bound step on the tail read back for mid
  assign rd_val = $signed(mem_rdata);
  assign lt     = rd_val < key_r;
  assign lo_n   = lt ? IDX_W'(mid_r + IDX_W'(1)) : lo_r;
  assign hi_n   = lt ? hi_r : mid_r;
  assign mid_n  = lo_n + ((hi_n - lo_n) >> 1);

  // Length after this element
  always_comb begin
    if (start_r) begin
      new_len = LEN_W'(1);
    end else if (ext_r) begin
      new_len = len_r + LEN_W'(1);
    end else begin
      new_len = len_r;
    end
  end

  assign stat.need_search = !fresh_r && !below && !above && (hi0 != '0);
  assign stat.found       = lo_n == hi_n;
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign mem_raddr = cmd.decide ? (hi0 >> 1) : mid_n;
  assign mem_we    = cmd.commit && !ovf_r;

  lts_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_LEN)
  ) u_tails (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_r),
    .wdata (key_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Capture the beat, decide, search, load the result register on commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_value;
      last_r <= in_last;
    end
    if (cmd.decide) begin
      start_r <= 1'b0;
      ext_r   <= 1'b0;
      ovf_r   <= 1'b0;
      slot_r  <= '0;
      lo_r    <= '0;
      hi_r    <= hi0;
      mid_r   <= hi0 >> 1;
      if (fresh_r) begin
        start_r <= 1'b1;
      end else if (below) begin
        slot_r <= '0;
      end else if (above) begin
        if (full) begin
          ovf_r  <= 1'b1;
          slot_r <= IDX_W'(MAX_LEN - 1);
        end else begin
          ext_r  <= 1'b1;
          slot_r <= IDX_W'(len_r);
        end
      end
    end
    if (cmd.search) begin
      lo_r  <= lo_n;
      hi_r  <= hi_n;
      mid_r <= mid_n;
      if (lo_n == hi_n) begin
        slot_r <= lo_n;
      end
    end
    // Mirror the first and last tail
    if (mem_we && slot_r == '0) begin
      tail0_r <= key_r;
    end
    if (mem_we && slot_r == IDX_W'(new_len - LEN_W'(1))) begin
      tlast_r <= key_r;
    end
    if (cmd.commit) begin
      out_slot_r <= SLOT_W'(slot_r);
      out_run_r  <= RUN_W'(new_len);
      out_ovf_r  <= ovf_r;
      out_done_r <= last_r;
    end
  end

  // Control state: length, fresh flag, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        len_r   <= new_len;
        fresh_r <= last_r;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_run_length = out_run_r;
  assign out_overflow   = out_ovf_r;
  assign out_done_res   = out_done_r;

endmodule

// ----- sim/tb_lis_length_tail_search_unit.sv -----
// Testbench for lis_length_tail_search_unit: a tail-store scoreboard predicts every result beat.
// Random gaps and output stalls are applied, and a long run fills the tail store to overflow.
// Depends on lts_pkg and the unit RTL.
module tb_lis_length_tail_search_unit
  import lts_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN     = 512;
  localparam int VALUE_BITS  = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [RUN_W-1:0]  run_length;
    logic              overflow;
    logic              done_res;
  } tail_result_t;

  // Tracks the smallest-tail store and queues the result each element should produce
  class tail_tracker;
    logic signed [VALUE_BITS-1:0] tails [MAX_LEN];
    int                           run_len;
    bit                           fresh;
    tail_result_t                 pending_results [$];
    int                           errors;

    function new();
      run_len = 0;
      fresh   = 1'b1;
      errors  = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Place one accepted element and queue its expected result
    function void note_element(logic signed [VALUE_BITS-1:0] v, logic l);
      tail_result_t r;
      int           slot;
      int           lo;
      int           hi;
      int           mid;
      r.overflow = 1'b0;
      if (fresh || run_len == 0) begin
        tails[0] = v;
        run_len  = 1;
        slot     = 0;
        fresh    = 1'b0;
      end else if (v < tails[0]) begin
        tails[0] = v;
        slot     = 0;
      end else if (v > tails[run_len-1]) begin
        if (run_len < MAX_LEN) begin
          slot          = run_len;
          tails[slot]   = v;
          run_len++;
        end else begin
          // store full: drop the extension
          slot       = MAX_LEN - 1;
          r.overflow = 1'b1;
        end
      end else begin
        // lower bound: first tail not below v
        lo = 0;
        hi = run_len;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (tails[mid] < v) lo = mid + 1;
          else hi = mid;
        end
        slot        = (lo >= MAX_LEN) ? MAX_LEN - 1 : lo;
        tails[slot] = v;
      end
      if (l) fresh = 1'b1;
      r.slot       = slot[SLOT_W-1:0];
      r.run_length = run_len[RUN_W-1:0];
      r.done_res   = l;
      pending_results.insert(pending_results.size(), r);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(tail_result_t got);
      tail_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (slot %0d run_length %0d)",
                 $time, got.slot, got.run_length);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.slot !== exp_r.slot) begin
        $display("%0t: slot expected %0d actual %0d", $time, exp_r.slot, got.slot);
        errors++;
      end
      if (got.run_length !== exp_r.run_length) begin
        $display("%0t: run_length expected %0d actual %0d", $time, exp_r.run_length,
                 got.run_length);
        errors++;
      end
      if (got.overflow !== exp_r.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, exp_r.overflow, got.overflow);
        errors++;
      end
      if (got.done_res !== exp_r.done_res) begin
        $display("%0t: done_res expected %0b actual %0b", $time, exp_r.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         in_last;
  logic                         out_valid;
  logic                         out_stall;
  logic [SLOT_W-1:0]            out_slot;
  logic [RUN_W-1:0]             out_run_length;
  logic                         out_overflow;
  logic                         out_done_res;

  tail_tracker sb;
  int          cycle_count;
  int          items_sent;
  int          stall_left;
  bit          calm;

  lis_length_tail_search_unit #(
    .MAX_LEN   (MAX_LEN),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_slot      (out_slot),
    .out_run_length(out_run_length),
    .out_overflow  (out_overflow),
    .out_done_res  (out_done_res)
  );

  always #2 clk = ~clk;

  // Mostly short idles, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    tail_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_element(in_value, in_last);
      if (out_valid && !out_stall) begin
        got.slot       = out_slot;
        got.run_length = out_run_length;
        got.overflow   = out_overflow;
        got.done_res   = out_done_res;
        sb.check_result(got);
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (stall_left == 0 && !calm && rst_n) stall_left = pick_idle();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one element beat; called and returns at a falling edge
  task automatic send_beat(input logic signed [VALUE_BITS-1:0] v, input logic l);
    int gap;
    gap = calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_value = v;
    in_last  = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Short sequence with one of several value styles
  task automatic run_short_sequence();
    int                           len;
    int                           style;
    int                           base;
    logic signed [VALUE_BITS-1:0] v;
    logic                         l;
    len   = $urandom_range(1, 24);
    style = $urandom_range(0, 3);
    base  = $urandom_range(0, 2000) - 1000;
    calm  = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      l = (i == len - 1);
      case (style)
        0: v = $urandom;
        1: v = $urandom_range(0, 40) - 20;
        2: v = base + i * $urandom_range(0, 50) - $urandom_range(0, 30);
        default: begin
          case ($urandom_range(0, 4))
            0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
            1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
            2: v = '0;
            3: v = '1;
            default: v = $urandom;
          endcase
          // broken sequences: end early at random
          if ($urandom_range(0, 4) == 0) l = 1'b1;
        end
      endcase
      send_beat(v, l);
    end
  endtask

  // Fill the tail store, then keep pushing extensions past the top
  task automatic run_full_sequence();
    longint start;
    longint cur;
    longint v;
    int     extra;
    start = -64'sd2147483648 + $urandom_range(0, 1000);
    cur   = start;
    extra = 0;
    calm  = 1'b0;
    while (extra < 10) begin
      if (sb.run_len >= MAX_LEN) extra++;
      if (extra == 10) begin
        send_beat({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b1);
      end else if ($urandom_range(0, 99) < 85) begin
        cur = cur + $urandom_range(1, 1000);
        send_beat(cur[VALUE_BITS-1:0], 1'b0);
      end else begin
        v = cur - $urandom_range(0, 4000);
        if (v < start) v = start;
        send_beat(v[VALUE_BITS-1:0], 1'b0);
      end
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    items_sent  = 0;
    calm        = 1'b0;
    sb          = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: first element, below tail 0, extend, inner replace, equal tail, extremes
    send_beat(0, 1'b0);
    send_beat({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b0);
    send_beat({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(7, 1'b1);
    send_beat({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
    send_beat({1'b0, {(VALUE_BITS-1){1'b1}}}, 1'b0);
    send_beat({1'b1, {(VALUE_BITS-1){1'b0}}}, 1'b1);
    send_beat(-1, 1'b1);
    send_beat(10, 1'b0);
    send_beat(20, 1'b0);
    send_beat(30, 1'b0);
    send_beat(40, 1'b0);
    send_beat(25, 1'b0);
    send_beat(10, 1'b0);
    send_beat(40, 1'b0);
    send_beat(41, 1'b1);
    drain_results();

    // Random: short sequences around one run that overflows the store
    while (items_sent < 50) run_short_sequence();
    run_full_sequence();
    drain_results();
    while (items_sent < 700) run_short_sequence();

    calm = 1'b0;
    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
